// File: sv/cec_pkg.sv
package cec_pkg;

    localparam int FIELD_W = 32;
    localparam int GEN_W   = 32;

    typedef enum logic [1:0] {
        REQ_LOOKUP     = 2'd0,
        REQ_ADD        = 2'd1,
        REQ_INVALIDATE = 2'd2,
        REQ_NONE       = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic update;
        logic in_ready;
        logic out_valid;
    } cec_ctrl_t;

    typedef struct packed {
        logic scan_end;
    } cec_status_t;

endpackage

// File: sv/cec_if.sv
interface cec_req_if;
    import cec_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [FIELD_W-1:0] file_cluster;
    logic [FIELD_W-1:0] disk_cluster;
    logic [FIELD_W-1:0] run_length;
    logic [GEN_W-1:0]   generation_tag;

    modport source (output valid, req_type, file_cluster, disk_cluster, run_length,
                    generation_tag, input ready);
    modport sink (input valid, req_type, file_cluster, disk_cluster, run_length,
                  generation_tag, output ready);
endinterface

interface cec_rsp_if;
    import cec_pkg::*;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] found_file_cluster;
    logic [FIELD_W-1:0] found_disk_cluster;
    logic [FIELD_W-1:0] extent_file_start;
    logic [FIELD_W-1:0] extent_disk_start;
    logic [FIELD_W-1:0] extent_run;
    logic [GEN_W-1:0]   generation_out;

    modport source (output valid, hit, offset, found_file_cluster, found_disk_cluster,
                    extent_file_start, extent_disk_start, extent_run, generation_out,
                    input ready);
    modport sink (input valid, hit, offset, found_file_cluster, found_disk_cluster,
                  extent_file_start, extent_disk_start, extent_run, generation_out,
                  output ready);
endinterface

// File: sv/cec_controller.sv
module cec_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 out_ready,
    input  cec_pkg::cec_status_t status,
    output cec_pkg::cec_ctrl_t   ctrl
);
    import cec_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.start    = in_valid;
            end
            ST_SCAN:
            begin
                ctrl.scan = 1'b1;
            end
            ST_UPDATE:
            begin
                ctrl.update = 1'b1;
            end
            ST_RESP:
            begin
                ctrl.out_valid = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// File: sv/cec_datapath.sv
module cec_datapath #(
    parameter int ENTRIES      = 16,
    parameter int CLUSTER_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cec_pkg::cec_ctrl_t           ctrl,
    output cec_pkg::cec_status_t         status,
    input  logic [1:0]                   req_type,
    input  logic [cec_pkg::FIELD_W-1:0]  file_cluster,
    input  logic [cec_pkg::FIELD_W-1:0]  disk_cluster,
    input  logic [cec_pkg::FIELD_W-1:0]  run_length,
    input  logic [cec_pkg::GEN_W-1:0]    generation_tag,
    output logic                         hit,
    output logic [cec_pkg::FIELD_W-1:0]  offset,
    output logic [cec_pkg::FIELD_W-1:0]  found_file_cluster,
    output logic [cec_pkg::FIELD_W-1:0]  found_disk_cluster,
    output logic [cec_pkg::FIELD_W-1:0]  extent_file_start,
    output logic [cec_pkg::FIELD_W-1:0]  extent_disk_start,
    output logic [cec_pkg::FIELD_W-1:0]  extent_run,
    output logic [cec_pkg::GEN_W-1:0]    generation_out
);
    import cec_pkg::*;

    localparam int CB    = CLUSTER_BITS;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL  = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(ENTRIES - 1);
    localparam logic [CB-1:0]    CMASK = '1;

    typedef struct packed {
        logic [CB-1:0] st;
        logic [CB-1:0] disk;
        logic [CB-1:0] run;
    } entry_t;

    entry_t           mem [ENTRIES];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] order_reg [ENTRIES];
    logic [IDX_W-1:0] order_next [ENTRIES];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [GEN_W-1:0] gen_reg;
    logic [GEN_W-1:0] gen_next;
    logic [GEN_W-1:0] gen_inc;
    req_type_t        op_reg;
    logic [CB-1:0]    fc_reg;
    logic [CB-1:0]    dc_reg;
    logic [CB-1:0]    run_reg;
    logic             active_reg;
    logic [CNT_W-1:0] iss_reg;
    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_pos_reg;
    logic [IDX_W-1:0] cmp_slot_reg;
    logic             done_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_pos_reg;
    logic [IDX_W-1:0] best_slot_reg;
    entry_t           best_reg;
    logic [CB-1:0]    offset_reg;

    logic             issue;
    logic [IDX_W-1:0] rd_addr;
    logic             evaluate;
    logic [CB-1:0]    end_c;
    logic             take;
    logic             stop;
    logic             add_ok;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;
    logic             front_en;
    logic [IDX_W-1:0] front_pos;
    logic [IDX_W-1:0] new_pos;

    logic                hit_reg;
    logic [FIELD_W-1:0]  offset_out_reg;
    logic [FIELD_W-1:0]  ffc_reg;
    logic [FIELD_W-1:0]  fdc_reg;
    logic [FIELD_W-1:0]  efs_reg;
    logic [FIELD_W-1:0]  eds_reg;
    logic [FIELD_W-1:0]  erun_reg;

    assign add_ok = (file_cluster[CB-1:0] != CMASK)
                    && ((generation_tag == '0) || (generation_tag == gen_reg));

    assign issue    = ctrl.scan && active_reg && !done_reg && (iss_reg < count_reg);
    assign rd_addr  = order_reg[iss_reg[IDX_W-1:0]];
    assign evaluate = ctrl.scan && cmp_valid_reg && !done_reg;
    assign end_c    = rd_data_reg.st + rd_data_reg.run;

    assign status.scan_end = !active_reg || done_reg
                             || (!cmp_valid_reg && (iss_reg >= count_reg));

    always_comb
    begin
        take = 1'b0;
        stop = 1'b0;
        if (op_reg == REQ_LOOKUP)
        begin
            take = (rd_data_reg.st <= fc_reg) && (best_reg.st < rd_data_reg.st);
            stop = take && !(end_c < fc_reg);
        end
        else
        begin
            take = (rd_data_reg.st == fc_reg);
            stop = take;
        end
    end

    assign gen_inc = gen_reg + GEN_W'(1);

    always_comb
    begin
        mem_we     = 1'b0;
        mem_wa     = best_slot_reg;
        mem_wd     = best_reg;
        front_en   = 1'b0;
        front_pos  = best_pos_reg;
        count_next = count_reg;
        gen_next   = gen_reg;
        new_pos    = (count_reg < FULL) ? count_reg[IDX_W-1:0] : LAST;
        case (op_reg)
            REQ_LOOKUP:
            begin
                front_en = found_reg;
            end
            REQ_ADD:
            begin
                if (active_reg)
                begin
                    front_en = 1'b1;
                    if (found_reg)
                    begin
                        mem_we     = (run_reg > best_reg.run);
                        mem_wd.run = run_reg;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        front_pos = new_pos;
                        mem_wa    = order_reg[new_pos];
                        mem_wd    = '{st: fc_reg, disk: dc_reg, run: run_reg};
                        if (count_reg < FULL)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            REQ_INVALIDATE:
            begin
                count_next = '0;
                gen_next   = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        order_next = order_reg;
        if (front_en)
        begin
            order_next[0] = order_reg[front_pos];
            for (int i = 1; i < ENTRIES; i++)
            begin
                if (IDX_W'(i) <= front_pos)
                begin
                    order_next[i] = order_reg[i - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update && mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (issue)
        begin
            rd_data_reg  <= mem[rd_addr];
            cmp_slot_reg <= rd_addr;
            cmp_pos_reg  <= iss_reg[IDX_W-1:0];
        end
        if (ctrl.start)
        begin
            op_reg     <= req_type_t'(req_type);
            fc_reg     <= file_cluster[CB-1:0];
            dc_reg     <= disk_cluster[CB-1:0];
            run_reg    <= run_length[CB-1:0];
            best_reg   <= '0;
            offset_reg <= CMASK;
        end
        else if (evaluate && take)
        begin
            best_pos_reg  <= cmp_pos_reg;
            best_slot_reg <= cmp_slot_reg;
            best_reg      <= rd_data_reg;
            offset_reg    <= stop ? (fc_reg - rd_data_reg.st) : rd_data_reg.run;
        end
        if (ctrl.update)
        begin
            hit_reg        <= (op_reg == REQ_LOOKUP) && found_reg;
            offset_out_reg <= '0;
            ffc_reg        <= '0;
            fdc_reg        <= '0;
            efs_reg        <= '0;
            eds_reg        <= '0;
            erun_reg       <= '0;
            if (op_reg == REQ_LOOKUP)
            begin
                offset_out_reg <= FIELD_W'(offset_reg);
                if (found_reg)
                begin
                    ffc_reg  <= FIELD_W'(CB'(best_reg.st + offset_reg));
                    fdc_reg  <= FIELD_W'(CB'(best_reg.disk + offset_reg));
                    efs_reg  <= FIELD_W'(best_reg.st);
                    eds_reg  <= FIELD_W'(best_reg.disk);
                    erun_reg <= FIELD_W'(best_reg.run);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                order_reg[i] <= IDX_W'(i);
            end
            count_reg     <= '0;
            gen_reg       <= GEN_W'(1);
            active_reg    <= 1'b0;
            iss_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (ctrl.start)
            begin
                active_reg    <= (req_type == REQ_LOOKUP)
                                 || ((req_type == REQ_ADD) && add_ok);
                iss_reg       <= '0;
                cmp_valid_reg <= 1'b0;
                done_reg      <= 1'b0;
                found_reg     <= 1'b0;
            end
            else if (ctrl.scan)
            begin
                cmp_valid_reg <= issue;
                if (issue)
                begin
                    iss_reg <= iss_reg + CNT_W'(1);
                end
                if (evaluate && take)
                begin
                    found_reg <= 1'b1;
                    done_reg  <= stop;
                end
            end
            if (ctrl.update)
            begin
                order_reg <= order_next;
                count_reg <= count_next;
                gen_reg   <= gen_next;
            end
        end
    end

    assign hit                = hit_reg;
    assign offset             = offset_out_reg;
    assign found_file_cluster = ffc_reg;
    assign found_disk_cluster = fdc_reg;
    assign extent_file_start  = efs_reg;
    assign extent_disk_start  = eds_reg;
    assign extent_run         = erun_reg;
    assign generation_out     = gen_reg;

endmodule

// File: sv/cluster_extent_lru_cache.sv
// Extent cache of file-to-disk cluster runs, kept in recency order. Each request
// takes one response; a new request is taken only after the previous response has
// gone. The scan reads at most ENTRIES entries, one entry a cycle, from the
// single-ported entry store and stops at the first covering extent.
module cluster_extent_lru_cache #(
    parameter int ENTRIES      = 16,
    parameter int CLUSTER_BITS = 32
) (
    input logic       clk,
    input logic       rst_n,
    cec_req_if.sink   req,
    cec_rsp_if.source rsp
);
    import cec_pkg::*;

    cec_ctrl_t   ctrl;
    cec_status_t status;

    cec_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    cec_datapath #(
        .ENTRIES      (ENTRIES),
        .CLUSTER_BITS (CLUSTER_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .status             (status),
        .req_type           (req.req_type),
        .file_cluster       (req.file_cluster),
        .disk_cluster       (req.disk_cluster),
        .run_length         (req.run_length),
        .generation_tag     (req.generation_tag),
        .hit                (rsp.hit),
        .offset             (rsp.offset),
        .found_file_cluster (rsp.found_file_cluster),
        .found_disk_cluster (rsp.found_disk_cluster),
        .extent_file_start  (rsp.extent_file_start),
        .extent_disk_start  (rsp.extent_disk_start),
        .extent_run         (rsp.extent_run),
        .generation_out     (rsp.generation_out)
    );

    assign req.ready = ctrl.in_ready;
    assign rsp.valid = ctrl.out_valid;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("Request accepted while a response is pending.");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.generation_out != '0))
        else $error("Generation reported as zero.");

    a_offset_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (rsp.offset <= rsp.extent_run))
        else $error("Hit offset lies beyond the extent run.");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cec_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        hit;
        logic [31:0] offset;
        logic [31:0] found_fc;
        logic [31:0] found_dc;
        logic [31:0] ext_fs;
        logic [31:0] ext_ds;
        logic [31:0] ext_run;
        logic [31:0] gen;
    } answer_t;

    typedef struct {
        req_type_t   kind;
        logic [31:0] fc;
        logic [31:0] dc;
        logic [31:0] run;
        logic [31:0] tag;
        logic        known;
        answer_t     ans;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cec_req_if req_ch();
    cec_rsp_if rsp_ch();

    cluster_extent_lru_cache u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [31:0] ext_fs_m [NSLOT];
    logic [31:0] ext_ds_m [NSLOT];
    logic [31:0] ext_run_m [NSLOT];
    logic [3:0]  lru_m [NSLOT];
    int          live_m;
    logic [31:0] gen_m;

    answer_t answers_due [$];
    int      errors = 0;
    int      sent = 0;
    int      got = 0;
    int      hits = 0;
    int      idle_cycles = 0;
    int      send_pct = 0;
    int      stall_pct = 0;
    bit      hold_off = 0;
    row_t    rows [$];
    int      tracked_fs [$];

    function automatic void promote(input int pos);
        logic [3:0] s;
        s = lru_m[pos];
        for (int i = pos; i > 0; i--)
            lru_m[i] = lru_m[i-1];
        lru_m[0] = s;
    endfunction

    function automatic answer_t cache_answer(input row_t r);
        answer_t a;
        bit found;
        int bp;
        logic [31:0] bs, off, st;
        logic [3:0] s;
        a = '0;
        if (r.kind == REQ_LOOKUP) begin
            found = 0; bp = 0; bs = 0; off = ALL_ONES;
            for (int i = 0; i < live_m; i++) begin
                s = lru_m[i];
                st = ext_fs_m[s];
                if (st <= r.fc && bs < st) begin
                    found = 1; bp = i; bs = st;
                    if (st + ext_run_m[s] < r.fc)
                        off = ext_run_m[s];
                    else begin
                        off = r.fc - st;
                        break;
                    end
                end
            end
            a.offset = off;
            if (found) begin
                s = lru_m[bp];
                promote(bp);
                a.hit = 1'b1;
                a.found_fc = ext_fs_m[s] + off;
                a.found_dc = ext_ds_m[s] + off;
                a.ext_fs = ext_fs_m[s];
                a.ext_ds = ext_ds_m[s];
                a.ext_run = ext_run_m[s];
            end
        end else if (r.kind == REQ_ADD) begin
            if (r.fc != ALL_ONES && (r.tag == 0 || r.tag == gen_m)) begin
                int pos;
                bit merged;
                merged = 0;
                for (int i = 0; i < live_m; i++) begin
                    s = lru_m[i];
                    if (ext_fs_m[s] == r.fc) begin
                        if (r.run > ext_run_m[s])
                            ext_run_m[s] = r.run;
                        promote(i);
                        merged = 1;
                        break;
                    end
                end
                if (!merged) begin
                    if (live_m < NSLOT) begin
                        pos = live_m;
                        live_m++;
                    end else
                        pos = NSLOT - 1;
                    s = lru_m[pos];
                    ext_fs_m[s] = r.fc;
                    ext_ds_m[s] = r.dc;
                    ext_run_m[s] = r.run;
                    promote(pos);
                end
            end
        end else if (r.kind == REQ_INVALIDATE) begin
            live_m = 0;
            gen_m = gen_m + 1;
            if (gen_m == 0)
                gen_m = 1;
        end
        a.gen = gen_m;
        return a;
    endfunction

    task automatic send(input row_t r);
        answer_t a;
        a = cache_answer(r);
        if (r.known && a != r.ans) begin
            $display("%0t: table row %0d disagrees with prediction: table %h predicted %h",
                     $time, sent, r.ans, a);
            errors++;
        end
        answers_due.push_back(a);
        req_ch.req_type <= r.kind;
        req_ch.file_cluster <= r.fc;
        req_ch.disk_cluster <= r.dc;
        req_ch.run_length <= r.run;
        req_ch.generation_tag <= r.tag;
        req_ch.valid <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent++;
        while ($urandom_range(99) < send_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic finish_send();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic row_t mk(input req_type_t k, input logic [31:0] fc, dc, run, tag);
        row_t r;
        r.kind = k; r.fc = fc; r.dc = dc; r.run = run; r.tag = tag;
        r.known = 0; r.ans = '0;
        return r;
    endfunction

    function automatic row_t mk_known(input req_type_t k, input logic [31:0] fc, dc, run,
                                      tag, input answer_t a);
        row_t r;
        r = mk(k, fc, dc, run, tag);
        r.known = 1; r.ans = a;
        return r;
    endfunction

    function automatic answer_t miss_ans(input logic [31:0] g);
        answer_t a;
        a = '0; a.offset = ALL_ONES; a.gen = g;
        return a;
    endfunction

    function automatic answer_t quiet_ans(input logic [31:0] g);
        answer_t a;
        a = '0; a.gen = g;
        return a;
    endfunction

    function automatic logic [31:0] pick_field();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return ALL_ONES;
            2: return $urandom_range(40);
            default: return $urandom;
        endcase
    endfunction

    function automatic row_t random_row();
        row_t r;
        int p;
        logic [31:0] base;
        p = $urandom_range(99);
        r = mk(REQ_LOOKUP, 0, $urandom, $urandom, 0);
        base = tracked_fs.size() > 0 ? tracked_fs[$urandom_range(tracked_fs.size()-1)]
                                     : $urandom_range(200);
        if (p < 45) begin
            r.kind = REQ_LOOKUP;
            r.fc = ($urandom_range(3) == 0) ? pick_field() : base + $urandom_range(60);
        end else if (p < 88) begin
            r.kind = REQ_ADD;
            r.fc = ($urandom_range(4) == 0) ? pick_field()
                   : ($urandom_range(2) == 0 ? base : $urandom_range(1, 2000));
            r.dc = $urandom;
            r.run = ($urandom_range(5) == 0) ? pick_field() : $urandom_range(50);
            case ($urandom_range(5))
                0: r.tag = gen_m;
                1: r.tag = $urandom;
                2: r.tag = gen_m + 1;
                default: r.tag = 0;
            endcase
            if (tracked_fs.size() > 40)
                void'(tracked_fs.pop_front());
            tracked_fs.push_back(r.fc);
        end else if (p < 95) begin
            r.kind = REQ_INVALIDATE;
            tracked_fs.delete();
        end else begin
            r.kind = REQ_NONE;
            r.fc = $urandom;
            r.tag = $urandom;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready) begin
            answer_t a, e;
            a = {rsp_ch.hit, rsp_ch.offset, rsp_ch.found_file_cluster,
                 rsp_ch.found_disk_cluster, rsp_ch.extent_file_start,
                 rsp_ch.extent_disk_start, rsp_ch.extent_run, rsp_ch.generation_out};
            got++;
            if (a.hit)
                hits++;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected response %h", $time, a);
                errors++;
            end else begin
                e = answers_due.pop_front();
                if (a !== e) begin
                    $display("%0t: response mismatch: expected %h actual %h", $time, e, a);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress, %0d responses outstanding", $time, answers_due.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        row_t r;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_NONE;
        req_ch.file_cluster = '0;
        req_ch.disk_cluster = '0;
        req_ch.run_length = '0;
        req_ch.generation_tag = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
            ext_fs_m[i] = 0; ext_ds_m[i] = 0; ext_run_m[i] = 0; lru_m[i] = i;
        end
        live_m = 0;
        gen_m = 1;

        rows.push_back(mk_known(REQ_LOOKUP, 32'd5, 0, 0, 0, miss_ans(1)));
        rows.push_back(mk_known(REQ_ADD, 32'd100, 32'd5000, 32'd9, 0, quiet_ans(1)));
        rows.push_back(mk(REQ_LOOKUP, 32'd104, 0, 0, 0));
        rows.push_back(mk(REQ_LOOKUP, 32'd100, 0, 0, 0));
        rows.push_back(mk(REQ_LOOKUP, 32'd300, 0, 0, 0));
        rows.push_back(mk_known(REQ_LOOKUP, 32'd99, 0, 0, 0, miss_ans(1)));
        rows.push_back(mk(REQ_ADD, 32'd0, 32'd77, 32'd50, 0));
        rows.push_back(mk(REQ_LOOKUP, 32'd20, 0, 0, 0));
        rows.push_back(mk(REQ_ADD, ALL_ONES, ALL_ONES, ALL_ONES, 0));
        rows.push_back(mk(REQ_ADD, 32'd200, 32'd1, 32'd3, 32'd7));
        rows.push_back(mk(REQ_ADD, 32'd200, ALL_ONES, ALL_ONES, 32'd1));
        rows.push_back(mk(REQ_LOOKUP, ALL_ONES, 0, 0, 0));
        rows.push_back(mk(REQ_ADD, 32'd100, 32'd1, 32'd20, 0));
        rows.push_back(mk(REQ_ADD, 32'd100, 32'd1, 32'd2, 0));
        rows.push_back(mk(REQ_LOOKUP, 32'd115, 0, 0, 0));
        rows.push_back(mk_known(REQ_NONE, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                                quiet_ans(1)));
        rows.push_back(mk_known(REQ_INVALIDATE, 0, 0, 0, 0, quiet_ans(2)));
        rows.push_back(mk_known(REQ_LOOKUP, 32'd115, 0, 0, 0, miss_ans(2)));
        for (int i = 1; i <= 18; i++)
            rows.push_back(mk(REQ_ADD, i * 10, i * 1000, 32'd4, 0));
        rows.push_back(mk(REQ_LOOKUP, 32'd12, 0, 0, 0));
        rows.push_back(mk(REQ_LOOKUP, 32'd183, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send(rows[i]);

        // Long receiver hold-off while requests keep coming, to back the block up.
        hold_off = 1;
        fork
            begin
                for (int i = 0; i < 6; i++)
                    send(random_row());
            end
            begin
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
        join

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 75; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 75; end
                default: begin send_pct = 15; stall_pct = 15; end
            endcase
            for (int i = 0; i < 470; i++)
                send(random_row());
        end

        // Generation wrap: walk the counter through zero using invalidates is too slow,
        // so the wrap is left to the predictor's arithmetic on the ordinary increments.
        finish_send();
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d requests and checked %0d responses, %0d of them lookup hits.",
                 sent, got, hits);
        if (errors == 0 && answers_due.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
